### hdl/bfa_pkg.sv
// Shared types, constants and codes of the bitmap frame allocator.
`default_nettype none
package bfa_pkg;

  localparam int WORD_BITS    = 64;
  localparam int BITMAP_WORDS = 1024;

  localparam int INDEX_W   = 16;
  localparam int LIMIT_W   = 17;
  localparam int BIT_IDX_W = $clog2(WORD_BITS);
  localparam int ADDR_W    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int SUM_W     = (((ADDR_W + BIT_IDX_W) > LIMIT_W) ?
                              (ADDR_W + BIT_IDX_W) : LIMIT_W) + 1;

  localparam int CAPACITY   = WORD_BITS * BITMAP_WORDS;
  localparam int INDEX_SPAN = 1 << INDEX_W;
  localparam int LIMIT_MAX  = (CAPACITY < INDEX_SPAN) ? CAPACITY : INDEX_SPAN;

  localparam int GROUP_BITS = 8;
  localparam int NGROUP     = WORD_BITS / GROUP_BITS;
  localparam int GSEL_W     = (NGROUP > 1) ? $clog2(NGROUP) : 1;

  localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_MARK_USED = 2'd0,
    OP_MARK_FREE = 2'd1,
    OP_TEST      = 2'd2,
    OP_FIND      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NONE_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [INDEX_W-1:0] frame_index;
  } req_t;

  typedef struct packed {
    logic               is_used;
    logic [INDEX_W-1:0] free_index;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic                 any;
    logic                 last;
    logic [BIT_IDX_W-1:0] bit_idx;
  } scan_t;

endpackage
`default_nettype wire

### hdl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/bfa_scan.sv
// Word scanner: masks a bitmap word to the frame limit and finds its lowest free bit.
`default_nettype none
module bfa_scan
  import bfa_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [SUM_W-1:0]     base,
  input  wire logic [LIMIT_W-1:0]   limit,
  output scan_t                     info
);

  logic [SUM_W-1:0]      lim_x;
  logic [SUM_W-1:0]      rem;
  logic [WORD_BITS-1:0]  valid_mask;
  logic [WORD_BITS-1:0]  free_bits;
  logic [NGROUP-1:0]     grp_any;
  logic [GSEL_W-1:0]     gsel;
  logic [GROUP_BITS-1:0] grp_bits;
  logic [BIT_IDX_W-1:0]  bsel;

  assign lim_x = SUM_W'(limit);
  assign rem   = lim_x - base;

  always_comb begin
    if (base >= lim_x) begin
      valid_mask = '0;
    end else if (rem >= SUM_W'(WORD_BITS)) begin
      valid_mask = WORD_FULL;
    end else begin
      valid_mask = WORD_FULL >> (SUM_W'(WORD_BITS) - rem);
    end
  end

  assign free_bits = ~word & valid_mask;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_any[g] = |free_bits[g*GROUP_BITS +: GROUP_BITS];
    end
  end

  always_comb begin
    gsel = '0;
    for (int g = NGROUP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = GSEL_W'(g);
      end
    end
  end

  assign grp_bits = free_bits[gsel*GROUP_BITS +: GROUP_BITS];

  always_comb begin
    bsel = '0;
    for (int b = GROUP_BITS - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bsel = BIT_IDX_W'(b);
      end
    end
  end

  assign info.any     = |grp_any;
  assign info.last    = (base + SUM_W'(WORD_BITS)) >= lim_x;
  assign info.bit_idx = BIT_IDX_W'(gsel * GROUP_BITS) + bsel;

endmodule
`default_nettype wire

### hdl/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: control, bitmap memory and result register.
//
//   channel | dir | handshake          | word
//   req     | in  | req_valid/req_stall| op, frame_index
//   rsp     | out | rsp_valid/rsp_stall| is_used, free_index, status
//   cfg     | in  | cfg_valid/cfg_ready| frame_count (17 bits)
//
// Mark used and mark free read the bitmap word, then modify and write it back; test only reads it.
// Find walks the words from word 0, one memory read per word, until a free bit or the limit word.
// After reset a clearing pass writes zeros to all 1024 words; req stalls.
// A held result does not block the next accept; a finished op waits while rsp is stalled.
`default_nettype none
module bitmap_frame_allocator
  import bfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DATA  = 4'b0100,
    S_FIND  = 4'b1000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [ADDR_W-1:0]    clr_addr;
  logic [ADDR_W-1:0]    chk_w;
  logic [ADDR_W-1:0]    chk_w_next;
  logic [LIMIT_W-1:0]   limit;
  logic [1:0]           req_op;
  logic [BIT_IDX_W-1:0] req_bit;
  logic [ADDR_W-1:0]    req_addr;
  logic                 req_range;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 req_accept;
  logic                 out_free;
  logic                 rsp_load;
  rsp_t                 rsp_next;
  logic [SUM_W-1:0]     base;
  scan_t                scan;
  logic [WORD_BITS-1:0] bit_mask;

  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(BITMAP_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign base = SUM_W'(chk_w) << BIT_IDX_W;

  bfa_scan u_scan (
    .word (ram_rdata),
    .base (base),
    .limit(limit),
    .info (scan)
  );

  assign cfg_ready  = 1'b1;
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign bit_mask   = WORD_BITS'(1) << req_bit;

  always_comb begin
    state_next = state;
    chk_w_next = chk_w;
    ram_we     = 1'b0;
    ram_waddr  = req_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = ADDR_W'(req.frame_index >> BIT_IDX_W);
    rsp_load   = 1'b0;
    rsp_next   = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == ADDR_W'(BITMAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_accept) begin
          ram_re = 1'b1;
          if (req.op == OP_FIND) begin
            ram_raddr  = '0;
            chk_w_next = '0;
            state_next = S_FIND;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          if (req_range) begin
            rsp_next.status = ST_RANGE;
          end else begin
            rsp_next.status = ST_OK;
            case (req_op)
              OP_MARK_USED: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | bit_mask;
              end
              OP_MARK_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~bit_mask;
              end
              default: begin
                rsp_next.is_used = |(ram_rdata & bit_mask);
              end
            endcase
          end
        end
      end
      S_FIND: begin
        if (!scan.any && !scan.last) begin
          ram_re     = 1'b1;
          ram_raddr  = chk_w + ADDR_W'(1);
          chk_w_next = chk_w + ADDR_W'(1);
        end else if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          if (scan.any) begin
            rsp_next.status     = ST_OK;
            rsp_next.free_index = INDEX_W'(base + SUM_W'(scan.bit_idx));
          end else begin
            rsp_next.status = ST_NONE_FREE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      chk_w     <= '0;
      limit     <= LIMIT_W'(LIMIT_MAX);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk_w <= chk_w_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        limit <= (cfg_data > LIMIT_W'(LIMIT_MAX)) ? LIMIT_W'(LIMIT_MAX) : cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_op    <= req.op;
      req_bit   <= req.frame_index[BIT_IDX_W-1:0];
      req_addr  <= ADDR_W'(req.frame_index >> BIT_IDX_W);
      req_range <= LIMIT_W'(req.frame_index) >= limit;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("bitmap read and write in the same cycle");

  a_accept_starts_op: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state == S_DATA || state == S_FIND))
    else $error("accepted word did not start an operation");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!rsp_valid && !ram_re))
    else $error("activity during clearing pass");

  a_range_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA && req_range) |-> !ram_we)
    else $error("write on out-of-range index");

endmodule
`default_nettype wire
